[hw/rtl/cube_map_texel_address_assert.svh]
// ----------------------------------------------------------------------------
// Cube map texel address assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_TEXEL_ADDRESS_ASSERT_SVH
`define CUBE_MAP_TEXEL_ADDRESS_ASSERT_SVH

// same-cycle implication
`define CMTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cmta_pkg.sv]
// ----------------------------------------------------------------------------
// Cube map texel address package
// Default widths, register map and face codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmta_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 12;

	localparam int REG_BITS   = 13;
	localparam int DATA_BITS  = 32;
	localparam int PADDR_BITS = 3;
	localparam int FACE_BITS  = 3;

	localparam logic REG_FACE_WIDTH  = 1'b0;
	localparam logic REG_FACE_HEIGHT = 1'b1;

	localparam logic [REG_BITS-1:0] SIZE_RESET = 13'd256;

	typedef enum logic [FACE_BITS-1:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

endpackage

[hw/rtl/cmta_div.sv]
// ----------------------------------------------------------------------------
// Cube map texel address divider
// Restoring divider, one quotient bit per register stage, all stages share
// one advance enable. The quotient must fit in QUO_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmta_div #(
	parameter int NUM_BITS = 30,
	parameter int DEN_BITS = 17,
	parameter int QUO_BITS = 13
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic [QUO_BITS-1:0] quo
);

	logic [NUM_BITS-1:0] rem_s [QUO_BITS-1];
	logic [DEN_BITS-1:0] den_s [QUO_BITS-1];
	logic [QUO_BITS-1:0] quo_s [QUO_BITS];

	for (genvar gi = 0; gi < QUO_BITS; gi++) begin : g_stage
		logic [NUM_BITS-1:0] rem_in;
		logic [DEN_BITS-1:0] den_in;
		logic [QUO_BITS-1:0] quo_in;
		logic [NUM_BITS-1:0] den_sh;
		logic [NUM_BITS:0]   diff;
		logic                q_bit;

		if (gi == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[gi-1];
			assign den_in = den_s[gi-1];
			assign quo_in = quo_s[gi-1];
		end

		assign den_sh = NUM_BITS'(den_in) << (QUO_BITS - 1 - gi);
		assign diff   = {1'b0, rem_in} - {1'b0, den_sh};
		assign q_bit  = !diff[NUM_BITS];

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[gi] <= {quo_in[QUO_BITS-2:0], q_bit};
			end
		end

		if (gi < QUO_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi] <= q_bit ? diff[NUM_BITS-1:0] : rem_in;
					den_s[gi] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[QUO_BITS-1];

endmodule

[hw/rtl/cube_map_texel_address.sv]
// ----------------------------------------------------------------------------
// Cube map texel address
// Picks the cube face of a signed direction vector by its largest absolute
// component (ties to z, then y) and maps the two tangent components onto the
// face as floor((m +/- t) * size / (2m)), clamped to size minus one. One vector
// is taken every cycle while dir_stall is low. The pipeline has one stage for
// magnitudes, one for face selection, one for the size multiply, SIZE_BITS + 1
// stages of the restoring divider (one quotient bit each), and the output
// register. A two-entry output buffer keeps the pipeline moving while a
// finished transfer waits; dir_stall rises only when both entries are full.
// face_width and face_height are written over the APB port at byte addresses
// 0 and 4; zero is treated as one, values above 2^SIZE_BITS saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cube_map_texel_address_assert.svh"

module cube_map_texel_address #(
	parameter int COORD_BITS = cmta_pkg::COORD_BITS_DEF,
	parameter int SIZE_BITS  = cmta_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cmta_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [cmta_pkg::DATA_BITS-1:0]    pwdata,
	output logic [cmta_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready,
	input  logic                              dir_valid,
	output logic                              dir_stall,
	input  logic signed [COORD_BITS-1:0]      dir_x,
	input  logic signed [COORD_BITS-1:0]      dir_y,
	input  logic signed [COORD_BITS-1:0]      dir_z,
	output logic                              texel_valid,
	input  logic                              texel_stall,
	output logic [cmta_pkg::FACE_BITS-1:0]    face,
	output logic [SIZE_BITS-1:0]              texel_col,
	output logic [SIZE_BITS-1:0]              texel_row,
	output logic                              zero_dir
);

	import cmta_pkg::*;

	localparam int AW   = COORD_BITS + 1;
	localparam int EW   = SIZE_BITS + 1;
	localparam int NW   = AW + EW;
	localparam int QB   = EW;
	localparam int CMPW = (REG_BITS > EW) ? REG_BITS : EW;

	typedef struct packed {
		logic [FACE_BITS-1:0] face;
		logic [SIZE_BITS-1:0] col;
		logic [SIZE_BITS-1:0] row;
		logic                 zero;
	} res_t;

	function automatic logic [EW-1:0] eff_size(input logic [REG_BITS-1:0] s);
		logic [CMPW-1:0] s_ext;
		logic [CMPW-1:0] s_max;
		logic [CMPW-1:0] s_eff;
		s_ext = CMPW'(s);
		s_max = CMPW'(1) << SIZE_BITS;
		if (s_ext == '0) begin
			s_eff = CMPW'(1);
		end else if (s_ext > s_max) begin
			s_eff = s_max;
		end else begin
			s_eff = s_ext;
		end
		return s_eff[EW-1:0];
	endfunction

	function automatic logic [SIZE_BITS-1:0] clamp_idx(input logic [EW-1:0] q,
			input logic [EW-1:0] sz);
		logic [EW-1:0] last;
		last = sz - EW'(1);
		return (q > last) ? last[SIZE_BITS-1:0] : q[SIZE_BITS-1:0];
	endfunction

	// configuration registers
	logic [REG_BITS-1:0] face_width_q;
	logic [REG_BITS-1:0] face_height_q;
	logic [EW-1:0]       eff_w;
	logic [EW-1:0]       eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q  <= SIZE_RESET;
			face_height_q <= SIZE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_FACE_WIDTH:  face_width_q  <= pwdata[REG_BITS-1:0];
				REG_FACE_HEIGHT: face_height_q <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FACE_WIDTH:  prdata = DATA_BITS'(face_width_q);
			REG_FACE_HEIGHT: prdata = DATA_BITS'(face_height_q);
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign eff_w  = eff_size(face_width_q);
	assign eff_h  = eff_size(face_height_q);

	// pipeline advance: stall everything only while the skid entry is full
	logic en;
	logic skid_vld_q;
	logic out_vld_q;
	logic push;

	assign en        = !skid_vld_q;
	assign dir_stall = skid_vld_q;

	// stage 1: magnitudes
	logic                         vld_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic [AW-1:0]                ax_s1, ay_s1, az_s1;
	logic signed [AW-1:0]         xe, ye, ze;

	assign xe = AW'(dir_x);
	assign ye = AW'(dir_y);
	assign ze = AW'(dir_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= dir_x;
			y_s1  <= dir_y;
			z_s1  <= dir_z;
			ax_s1 <= xe[AW-1] ? AW'(-xe) : AW'(xe);
			ay_s1 <= ye[AW-1] ? AW'(-ye) : AW'(ye);
			az_s1 <= ze[AW-1] ? AW'(-ze) : AW'(ze);
		end
	end

	// stage 2: face selection and tangent offsets
	logic                         vld_s2;
	logic [FACE_BITS-1:0]         face_s2;
	logic                         zero_s2;
	logic [AW-1:0]                au_s2, av_s2, den_s2;

	logic                         z_major, y_major;
	logic [AW-1:0]                m_sel;
	face_t                        face_sel;
	logic signed [COORD_BITS-1:0] tu, tv;
	logic                         nu, nv;
	logic signed [AW:0]           m_sx, tu_sx, tv_sx, su, sv;

	always_comb begin
		z_major = (az_s1 >= ax_s1) && (az_s1 >= ay_s1);
		y_major = !z_major && (ay_s1 >= ax_s1);
		if (z_major) begin
			m_sel    = az_s1;
			face_sel = (z_s1 > 0) ? FACE_POS_Z : FACE_NEG_Z;
			tu       = x_s1;
			nu       = !(z_s1 > 0);
			tv       = y_s1;
			nv       = 1'b1;
		end else if (y_major) begin
			m_sel    = ay_s1;
			face_sel = (y_s1 > 0) ? FACE_POS_Y : FACE_NEG_Y;
			tu       = x_s1;
			nu       = 1'b0;
			tv       = z_s1;
			nv       = !(y_s1 > 0);
		end else begin
			m_sel    = ax_s1;
			face_sel = (x_s1 > 0) ? FACE_POS_X : FACE_NEG_X;
			tu       = z_s1;
			nu       = (x_s1 > 0);
			tv       = y_s1;
			nv       = 1'b1;
		end
		m_sx  = $signed({1'b0, m_sel});
		tu_sx = (AW + 1)'(tu);
		tv_sx = (AW + 1)'(tv);
		su    = nu ? (m_sx - tu_sx) : (m_sx + tu_sx);
		sv    = nv ? (m_sx - tv_sx) : (m_sx + tv_sx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s2 <= face_sel;
			zero_s2 <= (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);
			au_s2   <= su[AW-1:0];
			av_s2   <= sv[AW-1:0];
			den_s2  <= {m_sel[AW-2:0], 1'b0};
		end
	end

	// stage 3: scale by face size
	logic                 vld_s3;
	logic [FACE_BITS-1:0] face_s3;
	logic                 zero_s3;
	logic [NW-1:0]        num_u_s3, num_v_s3;
	logic [AW-1:0]        den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s3  <= face_s2;
			zero_s3  <= zero_s2;
			num_u_s3 <= NW'(au_s2) * NW'(eff_w);
			num_v_s3 <= NW'(av_s2) * NW'(eff_h);
			den_s3   <= den_s2;
		end
	end

	// divider stages
	logic [EW-1:0]        quo_u, quo_v;
	logic                 div_vld_s  [QB];
	logic [FACE_BITS-1:0] div_face_s [QB];
	logic                 div_zero_s [QB];

	cmta_div #(
		.NUM_BITS (NW),
		.DEN_BITS (AW),
		.QUO_BITS (QB)
	) u_div_col (
		.clk (clk),
		.en  (en),
		.num (num_u_s3),
		.den (den_s3),
		.quo (quo_u)
	);

	cmta_div #(
		.NUM_BITS (NW),
		.DEN_BITS (AW),
		.QUO_BITS (QB)
	) u_div_row (
		.clk (clk),
		.en  (en),
		.num (num_v_s3),
		.den (den_s3),
		.quo (quo_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) begin
				div_vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			div_vld_s[0] <= vld_s3;
			for (int i = 1; i < QB; i++) begin
				div_vld_s[i] <= div_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_face_s[0] <= face_s3;
			div_zero_s[0] <= zero_s3;
			for (int i = 1; i < QB; i++) begin
				div_face_s[i] <= div_face_s[i-1];
				div_zero_s[i] <= div_zero_s[i-1];
			end
		end
	end

	// clamp and output buffer
	res_t res_new;
	res_t out_q;
	res_t skid_q;

	always_comb begin
		res_new.face = div_face_s[QB-1];
		res_new.zero = div_zero_s[QB-1];
		res_new.col  = div_zero_s[QB-1] ? '0 : clamp_idx(quo_u, eff_w);
		res_new.row  = div_zero_s[QB-1] ? '0 : clamp_idx(quo_v, eff_h);
	end

	assign push = en && div_vld_s[QB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !texel_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !texel_stall) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign texel_valid = out_vld_q;
	assign face        = out_q.face;
	assign texel_col   = out_q.col;
	assign texel_row   = out_q.row;
	assign zero_dir    = out_q.zero;

	`CMTA_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry without output entry")
	`CMTA_ASSERT_NXT(a_skid_fill, out_vld_q && texel_stall && push, skid_vld_q, "transfer dropped at full output")
	`CMTA_ASSERT_IMP(a_zero_result, texel_valid && zero_dir, texel_col == '0 && texel_row == '0 && face == FACE_NEG_Z, "zero vector result not cleared")
	`CMTA_ASSERT_IMP(a_col_clamp, texel_valid && !zero_dir, EW'(texel_col) < eff_w && EW'(texel_row) < eff_h, "texel index beyond face size")

endmodule
